// ===== rtl/mgpd_pkg.sv =====
// shared constants, phase codes and the result word type for the deframer
// no dependencies
package mgpd_pkg;

    localparam logic [7:0] BEGIN_MARK = 8'hC3;
    localparam logic [7:0] END_MARK   = 8'hC8;
    localparam logic [6:0] LOW7       = 7'h7F;
    localparam logic [7:0] HIGH_BIT   = 8'h80;

    localparam int HDR_LEN   = 7;
    localparam int GROUP_LEN = 7;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_MARKER = 3'd2;
    localparam logic [2:0] PH_BYTES  = 3'd3;
    localparam logic [2:0] PH_CHK1   = 3'd4;
    localparam logic [2:0] PH_CHK2   = 3'd5;
    localparam logic [2:0] PH_END    = 3'd6;

    localparam logic [2:0] HDR_ODD_IDX   = 3'd5;
    localparam logic [2:0] HDR_GROUP_IDX = 3'd6;

    localparam logic KIND_BODY    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] VERDICT_CHK_BIT = 2'b01;
    localparam logic [1:0] VERDICT_END_BIT = 2'b10;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] body_byte;
        logic [1:0] verdict;
        logic [6:0] dest_id;
        logic [6:0] source_id;
        logic [6:0] packet_type;
        logic [6:0] aux_field;
        logic [6:0] status_field;
        logic [9:0] body_length;
        logic       last_item;
    } t_result;

endpackage

// ===== rtl/mgpd_core.sv =====
// frame phase tracking, header capture, body byte restore and checksum
// depends on mgpd_pkg
module mgpd_core
    import mgpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [2:0] r_phase, n_phase;
    logic [6:0] r_hdr [HDR_LEN];
    logic [6:0] n_hdr [HDR_LEN];
    logic [2:0] r_hdr_idx, n_hdr_idx;
    logic [6:0] r_marker, n_marker;
    logic [6:0] r_pos, n_pos;
    logic [6:0] r_groups, n_groups;
    logic [7:0] r_chk, n_chk;
    logic [7:0] r_chk1, n_chk1;
    logic [9:0] r_count, n_count;
    logic       r_odd, n_odd;

    logic [6:0] low7;
    logic [2:0] bit_sel;
    logic       hi_bit;
    logic [7:0] body;
    logic [6:0] pos_inc;
    logic [6:0] sec_len;
    logic [7:0] got;

    assign low7    = i_byte[6:0] & LOW7;
    assign bit_sel = 3'd6 - r_pos[2:0];
    assign hi_bit  = (r_pos < 7'(GROUP_LEN)) && r_marker[bit_sel];
    assign body    = {hi_bit, low7} | (hi_bit ? HIGH_BIT : 8'h00);
    assign pos_inc = r_pos + 7'd1;
    assign sec_len = r_odd ? r_hdr[HDR_ODD_IDX] : 7'(GROUP_LEN);
    assign got     = {i_byte[6:0], 1'b1} & r_chk1;

    always_comb begin
        n_phase     = r_phase;
        n_hdr       = r_hdr;
        n_hdr_idx   = r_hdr_idx;
        n_marker    = r_marker;
        n_pos       = r_pos;
        n_groups    = r_groups;
        n_chk       = r_chk;
        n_chk1      = r_chk1;
        n_count     = r_count;
        n_odd       = r_odd;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_en) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_byte == BEGIN_MARK) begin
                        n_phase   = PH_HEADER;
                        n_hdr_idx = 3'd0;
                        n_chk     = 8'h00;
                        n_count   = 10'd0;
                    end
                end
                PH_HEADER: begin
                    n_hdr[r_hdr_idx] = low7;
                    n_chk            = r_chk ^ i_byte;
                    if (r_hdr_idx == HDR_GROUP_IDX) begin
                        n_hdr_idx = 3'd0;
                        n_groups  = low7;
                        if (r_hdr[HDR_ODD_IDX] != 7'd0) begin
                            n_odd   = 1'b1;
                            n_phase = PH_MARKER;
                        end else if (low7 != 7'd0) begin
                            n_groups = low7 - 7'd1;
                            n_odd    = 1'b0;
                            n_phase  = PH_MARKER;
                        end else begin
                            n_phase = PH_CHK1;
                        end
                    end else begin
                        n_hdr_idx = r_hdr_idx + 3'd1;
                    end
                end
                PH_MARKER: begin
                    n_marker = low7;
                    n_pos    = 7'd0;
                    n_phase  = PH_BYTES;
                end
                PH_BYTES: begin
                    n_chk   = r_chk ^ body;
                    n_count = r_count + 10'd1;
                    n_pos   = pos_inc;
                    if (pos_inc >= sec_len) begin
                        if (r_groups != 7'd0) begin
                            n_groups = r_groups - 7'd1;
                            n_odd    = 1'b0;
                            n_phase  = PH_MARKER;
                        end else begin
                            n_phase = PH_CHK1;
                        end
                    end
                    o_res_valid     = 1'b1;
                    o_res.item_kind = KIND_BODY;
                    o_res.body_byte = body;
                end
                PH_CHK1: begin
                    n_chk1  = i_byte;
                    n_phase = PH_CHK2;
                end
                PH_CHK2: begin
                    n_chk   = r_chk ^ got;
                    n_phase = PH_END;
                end
                default: begin
                    o_res_valid        = 1'b1;
                    o_res.item_kind    = KIND_VERDICT;
                    o_res.verdict      = ((r_chk != 8'h00) ? VERDICT_CHK_BIT : 2'b00)
                                       | ((i_byte != END_MARK) ? VERDICT_END_BIT : 2'b00);
                    o_res.dest_id      = r_hdr[0];
                    o_res.source_id    = r_hdr[1];
                    o_res.packet_type  = r_hdr[2];
                    o_res.aux_field    = r_hdr[3];
                    o_res.status_field = r_hdr[4];
                    o_res.body_length  = r_count;
                    o_res.last_item    = 1'b1;
                    n_phase            = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_hdr     <= '{default: '0};
            r_hdr_idx <= '0;
            r_marker  <= '0;
            r_pos     <= '0;
            r_groups  <= '0;
            r_chk     <= '0;
            r_chk1    <= '0;
            r_count   <= '0;
            r_odd     <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_hdr     <= n_hdr;
            r_hdr_idx <= n_hdr_idx;
            r_marker  <= n_marker;
            r_pos     <= n_pos;
            r_groups  <= n_groups;
            r_chk     <= n_chk;
            r_chk1    <= n_chk1;
            r_count   <= n_count;
            r_odd     <= n_odd;
        end
    end

    a_begin_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_HUNT && i_byte == BEGIN_MARK) |=> (r_phase == PH_HEADER))
        else $error("begin marker did not open a header");

    a_verdict_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.item_kind == KIND_VERDICT)
            |-> (o_res.last_item && o_res.body_byte == 8'h00))
        else $error("verdict word malformed");

    a_body_only_in_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.item_kind == KIND_BODY) |-> (r_phase == PH_BYTES))
        else $error("body word outside a section");

    a_hdr_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_idx <= HDR_GROUP_IDX)
        else $error("header index out of range");

endmodule

// ===== rtl/marker_group_packet_deframer.sv =====
// top level: marker-grouped packet deframer with a two-entry output buffer
// depends on mgpd_pkg and mgpd_core
//
// One wire byte is taken per clock while o_stall is low. Each accepted
// byte updates the frame phase and checksum; a restored body byte or the
// end-of-frame verdict word is formed from its wire byte and registered
// into a main output register, or into one skid entry behind it while main
// is held, so input keeps flowing while a result waits; o_stall rises only
// when both entries hold words, and is driven from a register.
module marker_group_packet_deframer
    import mgpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_wire_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_item_kind,
    output logic [7:0] o_body_byte,
    output logic [1:0] o_verdict,
    output logic [6:0] o_dest_id,
    output logic [6:0] o_source_id,
    output logic [6:0] o_packet_type,
    output logic [6:0] o_aux_field,
    output logic [6:0] o_status_field,
    output logic [9:0] o_body_length,
    output logic       o_last_item
);

    logic    accept;
    logic    res_valid;
    t_result res;
    logic    push, pop;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;

    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !r_skid_valid;

    mgpd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (accept),
        .i_byte      (i_wire_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign push = res_valid;
    assign pop  = r_main_valid && !i_stall;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop) begin
            if (push) begin
                n_main       = res;
                n_main_valid = 1'b1;
            end else begin
                n_main       = r_skid;
                n_main_valid = r_skid_valid;
                n_skid_valid = 1'b0;
            end
        end else if (push) begin
            if (!r_main_valid) begin
                n_main       = res;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_valid        = r_main_valid;
    assign o_item_kind    = r_main.item_kind;
    assign o_body_byte    = r_main.body_byte;
    assign o_verdict      = r_main.verdict;
    assign o_dest_id      = r_main.dest_id;
    assign o_source_id    = r_main.source_id;
    assign o_packet_type  = r_main.packet_type;
    assign o_aux_field    = r_main.aux_field;
    assign o_status_field = r_main.status_field;
    assign o_body_length  = r_main.body_length;
    assign o_last_item    = r_main.last_item;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held with empty main register");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !res_valid)
        else $error("result produced with both entries full");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_main_valid && !r_skid_valid))
        else $error("skid entry not moved into main register");

endmodule
